// ----- hdl/ivr_pkg.sv -----
// ivr_pkg: shared types and constants for the inverse-variance rebin core
// (queue item, divider request/response, register indexes, fixed widths).
// no dependencies
package ivr_pkg;

    localparam int MAX_GROUP_DEF    = 256;
    localparam int MAX_OUT_BINS_DEF = 65536;

    localparam int CW         = 32;   // content / error width
    localparam int GS_W       = 9;    // group_size register width
    localparam int OB_W       = 16;   // out_bin width
    localparam int ADDR_W     = 3;    // apb byte address width
    localparam int QDEPTH     = 2;    // front/back queue depth
    localparam int DIV_NUM_W  = 80;   // dividend shift register width
    localparam int DIV_CNT_W  = 7;

    localparam logic [DIV_CNT_W-1:0] REC_STEPS  = 7'd65;  // 2^64 / d
    localparam logic [DIV_CNT_W-1:0] FRAC_STEPS = 7'd80;  // n * 2^16 / d

    typedef enum logic [0:0] {
        REG_GROUP_SIZE = 1'b0
    } t_reg_idx;

    // one classified bin as queued between front and back
    typedef struct packed {
        logic [CW-1:0] mag;      // |content|
        logic          neg;      // content < 0
        logic [CW-1:0] err;
        logic          first;
        logic          skip;     // error is zero
        logic          unit;     // error of one raw unit, weight saturates
    } t_item;

    typedef struct packed {
        logic                  start;
        logic [DIV_NUM_W-1:0]  num;    // dividend, msb first
        logic [63:0]           den;
        logic [DIV_CNT_W-1:0]  steps;
    } t_div_req;

    typedef struct packed {
        logic        done;
        logic [63:0] quot;
        logic        ovf;    // quotient did not fit 64 bits
    } t_div_rsp;

endpackage

// ----- hdl/ivr_front.sv -----
// ivr_front: input transaction intake, bin classification and the short
// queue toward the back end. depends on ivr_pkg
module ivr_front (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_valid,
    output logic                   o_stall,
    input  logic [ivr_pkg::CW-1:0] i_content,
    input  logic [ivr_pkg::CW-1:0] i_bin_error,
    input  logic                   i_first_bin,
    input  logic                   i_pop,
    output logic                   o_q_valid,
    output ivr_pkg::t_item         o_q_item
);

    localparam int PW = (ivr_pkg::QDEPTH > 1) ? $clog2(ivr_pkg::QDEPTH) : 1;
    localparam int CNT_W = $clog2(ivr_pkg::QDEPTH + 1);
    localparam logic [PW-1:0] LAST = PW'(ivr_pkg::QDEPTH - 1);
    localparam logic [CNT_W-1:0] FULL = CNT_W'(ivr_pkg::QDEPTH);

    ivr_pkg::t_item r_mem [ivr_pkg::QDEPTH];
    logic [PW-1:0]    r_wr, r_rd, n_wr, n_rd;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    ivr_pkg::t_item   item;
    logic             push, pop;

    always_comb begin
        item.neg   = i_content[ivr_pkg::CW-1];
        item.mag   = i_content[ivr_pkg::CW-1] ? (~i_content + 1'b1) : i_content;
        item.err   = i_bin_error;
        item.first = i_first_bin;
        item.skip  = (i_bin_error == '0);
        item.unit  = (i_bin_error == ivr_pkg::CW'(1));
    end

    assign o_stall   = (r_cnt == FULL);
    assign o_q_valid = (r_cnt != '0);
    assign o_q_item  = r_mem[r_rd];
    assign push      = i_valid && !o_stall;
    assign pop       = i_pop && o_q_valid;

    always_comb begin
        n_wr  = push ? ((r_wr == LAST) ? '0 : r_wr + 1'b1) : r_wr;
        n_rd  = pop  ? ((r_rd == LAST) ? '0 : r_rd + 1'b1) : r_rd;
        n_cnt = r_cnt + CNT_W'(push) - CNT_W'(pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr] <= item;
        end
    end

endmodule

// ----- hdl/ivr_div.sv -----
// ivr_div: shared restoring divider, one quotient bit per cycle
// used for weight reciprocals, the group mean and the error reciprocal. depends on ivr_pkg
module ivr_div (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  ivr_pkg::t_div_req i_req,
    output ivr_pkg::t_div_rsp o_rsp
);

    logic [64:0]                       r_rem, n_rem, rem_sh;
    logic [ivr_pkg::DIV_NUM_W-1:0]     r_num, n_num;
    logic [63:0]                       r_den, n_den, r_quo, n_quo;
    logic                              r_ovf, n_ovf, r_busy, n_busy, r_done, n_done;
    logic [ivr_pkg::DIV_CNT_W-1:0]     r_cnt, n_cnt;
    logic                              ge;

    assign rem_sh = {r_rem[63:0], r_num[ivr_pkg::DIV_NUM_W-1]};
    assign ge     = (rem_sh >= {1'b0, r_den});

    always_comb begin
        n_rem  = r_rem;
        n_num  = r_num;
        n_den  = r_den;
        n_quo  = r_quo;
        n_ovf  = r_ovf;
        n_cnt  = r_cnt;
        n_busy = r_busy;
        n_done = 1'b0;
        if (i_req.start) begin
            n_rem  = '0;
            n_num  = i_req.num;
            n_den  = i_req.den;
            n_quo  = '0;
            n_ovf  = 1'b0;
            n_cnt  = i_req.steps;
            n_busy = 1'b1;
        end else if (r_busy) begin
            n_rem = ge ? (rem_sh - {1'b0, r_den}) : rem_sh;
            n_num = {r_num[ivr_pkg::DIV_NUM_W-2:0], 1'b0};
            n_quo = {r_quo[62:0], ge};
            n_ovf = r_ovf | r_quo[63];
            n_cnt = r_cnt - 1'b1;
            if (r_cnt == ivr_pkg::DIV_CNT_W'(1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rem <= n_rem;
        r_num <= n_num;
        r_den <= n_den;
        r_quo <= n_quo;
        r_ovf <= n_ovf;
        r_cnt <= n_cnt;
    end

    assign o_rsp.done = r_done;
    assign o_rsp.quot = r_quo;
    assign o_rsp.ovf  = r_ovf;

endmodule

// ----- hdl/ivr_back.sv -----
// ivr_back: per-bin weight and accumulation sequencer, group close-out
// (mean, reciprocal, square root) and the output register. depends on ivr_pkg
module ivr_back #(
    parameter int MAX_GROUP    = ivr_pkg::MAX_GROUP_DEF,
    parameter int MAX_OUT_BINS = ivr_pkg::MAX_OUT_BINS_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic [ivr_pkg::GS_W-1:0] i_group_size,
    input  logic                     i_q_valid,
    input  ivr_pkg::t_item           i_q_item,
    output logic                     o_pop,
    output ivr_pkg::t_div_req        o_div_req,
    input  ivr_pkg::t_div_rsp        i_div_rsp,
    output logic                     o_valid,
    input  logic                     i_stall,
    output logic [ivr_pkg::CW-1:0]   o_mean,
    output logic [ivr_pkg::CW-1:0]   o_mean_error,
    output logic [ivr_pkg::OB_W-1:0] o_out_bin,
    output logic                     o_empty_res,
    output logic                     o_saturated
);

    localparam int FW = $clog2(MAX_GROUP + 1);
    localparam logic [16:0] G_MAX    = 17'(MAX_GROUP);
    localparam logic [16:0] OB_LAST  = 17'(MAX_OUT_BINS - 1);
    localparam logic [63:0] I64_MAX  = 64'h7FFF_FFFF_FFFF_FFFF;
    localparam logic [63:0] U64_MAX  = 64'hFFFF_FFFF_FFFF_FFFF;

    typedef enum logic [12:0] {
        ST_IDLE = 13'b0000000000001,
        ST_SQ   = 13'b0000000000010,
        ST_RECW = 13'b0000000000100,
        ST_WADD = 13'b0000000001000,
        ST_MLO  = 13'b0000000010000,
        ST_MHI  = 13'b0000000100000,
        ST_MSAT = 13'b0000001000000,
        ST_ACC  = 13'b0000010000000,
        ST_FILL = 13'b0000100000000,
        ST_MEAN = 13'b0001000000000,
        ST_RECE = 13'b0010000000000,
        ST_SQRT = 13'b0100000000000,
        ST_OUT  = 13'b1000000000000
    } t_state;

    t_state r_state, n_state;

    // current bin
    logic [31:0] r_mag, n_mag, r_e, n_e;
    logic        r_neg, n_neg;
    logic [63:0] r_w, n_w, r_plo, n_plo, r_phi, n_phi, r_m, n_m;
    // group accumulators
    logic signed [63:0] r_csum, n_csum;
    logic [63:0]        r_wsum, n_wsum;
    logic [FW-1:0]      r_fill, n_fill;
    logic [15:0]        r_nob, n_nob;
    logic               r_sat, n_sat;
    // group result
    logic        r_gneg, n_gneg;
    logic [31:0] r_rmean, n_rmean, r_rerr, n_rerr;
    logic        r_rempty, n_rempty, r_rsat, n_rsat;
    // square root
    logic [63:0] r_sv, n_sv, r_sr, n_sr, r_sb, n_sb;
    // divider request
    ivr_pkg::t_div_req r_div, n_div;
    // output register
    logic        r_ovalid, n_ovalid;
    logic [31:0] r_omean, n_omean, r_oerr, n_oerr;
    logic [15:0] r_obin, n_obin;
    logic        r_oempty, n_oempty, r_osat, n_osat;

    logic [31:0] mul_a, mul_b;
    logic [63:0] mul_p;
    logic [16:0] g_eff, gs17;
    logic        grp_done;
    logic [64:0] wsum_x, csum_x;
    logic signed [63:0] t_add;
    logic [63:0] low48, limit, csum_mag, trial, q32cap;
    logic        slot_free;

    // shared multiplier: error square, then content times both weight halves
    always_comb begin
        unique case (r_state)
            ST_MLO:  begin mul_a = r_mag; mul_b = r_w[31:0];  end
            ST_MHI:  begin mul_a = r_mag; mul_b = r_w[63:32]; end
            default: begin mul_a = r_e;   mul_b = r_e;        end
        endcase
    end
    assign mul_p = 64'(mul_a) * 64'(mul_b);

    always_comb begin
        gs17 = 17'(i_group_size);
        if (gs17 == '0) begin
            g_eff = 17'd1;
        end else if (gs17 > G_MAX) begin
            g_eff = G_MAX;
        end else begin
            g_eff = gs17;
        end
    end
    assign grp_done = ((17'(r_fill) + 17'd1) >= g_eff);

    assign wsum_x   = {1'b0, r_wsum} + {1'b0, r_w};
    assign t_add    = r_neg ? -$signed(r_m) : $signed(r_m);
    assign csum_x   = {r_csum[63], r_csum} + {t_add[63], t_add};
    assign low48    = {16'd0, r_plo[63:16]};
    assign limit    = (I64_MAX - low48) >> 16;
    assign csum_mag = r_csum[63] ? (64'd0 - r_csum) : r_csum;
    assign trial    = r_sr + r_sb;
    assign q32cap   = r_gneg ? 64'h8000_0000 : 64'h7FFF_FFFF;
    assign slot_free = !r_ovalid || !i_stall;
    assign o_pop    = (r_state == ST_IDLE);

    always_comb begin
        n_state = r_state;
        n_mag = r_mag; n_e = r_e; n_neg = r_neg; n_w = r_w;
        n_plo = r_plo; n_phi = r_phi; n_m = r_m;
        n_csum = r_csum; n_wsum = r_wsum; n_fill = r_fill; n_nob = r_nob; n_sat = r_sat;
        n_gneg = r_gneg; n_rmean = r_rmean; n_rerr = r_rerr;
        n_rempty = r_rempty; n_rsat = r_rsat;
        n_sv = r_sv; n_sr = r_sr; n_sb = r_sb;
        n_div = r_div;
        n_div.start = 1'b0;
        n_ovalid = r_ovalid && i_stall;
        n_omean = r_omean; n_oerr = r_oerr; n_obin = r_obin;
        n_oempty = r_oempty; n_osat = r_osat;

        unique case (r_state)
            ST_IDLE: begin
                if (i_q_valid) begin
                    n_mag = i_q_item.mag;
                    n_neg = i_q_item.neg;
                    n_e   = i_q_item.err;
                    if (i_q_item.first) begin
                        n_csum = '0;
                        n_wsum = '0;
                        n_fill = '0;
                        n_sat  = 1'b0;
                        n_nob  = '0;
                    end
                    priority if (i_q_item.skip) begin
                        n_state = ST_FILL;
                    end else if (i_q_item.unit) begin
                        n_w     = U64_MAX;
                        n_sat   = 1'b1;
                        n_state = ST_WADD;
                    end else begin
                        n_state = ST_SQ;
                    end
                end
            end
            ST_SQ: begin
                n_div.start = 1'b1;
                n_div.num   = {1'b1, {(ivr_pkg::DIV_NUM_W-1){1'b0}}};
                n_div.den   = mul_p;
                n_div.steps = ivr_pkg::REC_STEPS;
                n_state     = ST_RECW;
            end
            ST_RECW: begin
                if (i_div_rsp.done) begin
                    n_w     = i_div_rsp.quot;
                    n_state = ST_WADD;
                end
            end
            ST_WADD: begin
                if (wsum_x[64]) begin
                    n_wsum = U64_MAX;
                    n_sat  = 1'b1;
                end else begin
                    n_wsum = wsum_x[63:0];
                end
                n_state = ST_MLO;
            end
            ST_MLO: begin
                n_plo   = mul_p;
                n_state = ST_MHI;
            end
            ST_MHI: begin
                n_phi   = mul_p;
                n_state = ST_MSAT;
            end
            ST_MSAT: begin
                if (r_phi > limit) begin
                    n_m   = I64_MAX;
                    n_sat = 1'b1;
                end else begin
                    n_m = (r_phi << 16) + low48;
                end
                n_state = ST_ACC;
            end
            ST_ACC: begin
                if (csum_x[64] != csum_x[63]) begin
                    n_csum = csum_x[64] ? $signed(64'h8000_0000_0000_0000)
                                        : $signed(I64_MAX);
                    n_sat  = 1'b1;
                end else begin
                    n_csum = $signed(csum_x[63:0]);
                end
                n_state = ST_FILL;
            end
            ST_FILL: begin
                if (!grp_done) begin
                    n_fill  = r_fill + 1'b1;
                    n_state = ST_IDLE;
                end else if (r_wsum == '0) begin
                    n_rmean  = '0;
                    n_rerr   = '0;
                    n_rempty = 1'b1;
                    n_rsat   = r_sat;
                    n_state  = ST_OUT;
                end else begin
                    n_gneg      = r_csum[63];
                    n_rempty    = 1'b0;
                    n_div.start = 1'b1;
                    n_div.num   = {csum_mag, 16'd0};
                    n_div.den   = r_wsum;
                    n_div.steps = ivr_pkg::FRAC_STEPS;
                    n_state     = ST_MEAN;
                end
            end
            ST_MEAN: begin
                if (i_div_rsp.done) begin
                    if (i_div_rsp.ovf || (i_div_rsp.quot > q32cap)) begin
                        n_rmean = r_gneg ? (32'd0 - q32cap[31:0]) : q32cap[31:0];
                        n_rsat  = 1'b1;
                    end else begin
                        n_rmean = r_gneg ? (32'd0 - i_div_rsp.quot[31:0])
                                         : i_div_rsp.quot[31:0];
                        n_rsat  = r_sat;
                    end
                    if (r_wsum == 64'd1) begin
                        n_rerr  = 32'hFFFF_FFFF;
                        n_rsat  = 1'b1;
                        n_state = ST_OUT;
                    end else begin
                        n_div.start = 1'b1;
                        n_div.num   = {1'b1, {(ivr_pkg::DIV_NUM_W-1){1'b0}}};
                        n_div.den   = r_wsum;
                        n_div.steps = ivr_pkg::REC_STEPS;
                        n_state     = ST_RECE;
                    end
                end
            end
            ST_RECE: begin
                if (i_div_rsp.done) begin
                    n_sv    = i_div_rsp.quot;
                    n_sr    = '0;
                    n_sb    = 64'h4000_0000_0000_0000;
                    n_state = ST_SQRT;
                end
            end
            ST_SQRT: begin
                if (r_sb == '0) begin
                    if (r_sr[63:32] != '0) begin
                        n_rerr = 32'hFFFF_FFFF;
                        n_rsat = 1'b1;
                    end else begin
                        n_rerr = r_sr[31:0];
                    end
                    n_state = ST_OUT;
                end else begin
                    if (r_sv >= trial) begin
                        n_sv = r_sv - trial;
                        n_sr = (r_sr >> 1) + r_sb;
                    end else begin
                        n_sr = r_sr >> 1;
                    end
                    n_sb = r_sb >> 2;
                end
            end
            ST_OUT: begin
                if (slot_free) begin
                    n_ovalid = 1'b1;
                    n_omean  = r_rmean;
                    n_oerr   = r_rerr;
                    n_obin   = r_nob;
                    n_oempty = r_rempty;
                    n_osat   = r_rsat;
                    n_csum   = '0;
                    n_wsum   = '0;
                    n_fill   = '0;
                    n_sat    = 1'b0;
                    n_nob    = (17'(r_nob) >= OB_LAST) ? '0 : r_nob + 1'b1;
                    n_state  = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_csum      <= '0;
            r_wsum      <= '0;
            r_fill      <= '0;
            r_nob       <= '0;
            r_sat       <= 1'b0;
            r_div.start <= 1'b0;
            r_ovalid    <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_csum      <= n_csum;
            r_wsum      <= n_wsum;
            r_fill      <= n_fill;
            r_nob       <= n_nob;
            r_sat       <= n_sat;
            r_div.start <= n_div.start;
            r_ovalid    <= n_ovalid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_mag <= n_mag; r_e <= n_e; r_neg <= n_neg; r_w <= n_w;
        r_plo <= n_plo; r_phi <= n_phi; r_m <= n_m;
        r_gneg <= n_gneg; r_rmean <= n_rmean; r_rerr <= n_rerr;
        r_rempty <= n_rempty; r_rsat <= n_rsat;
        r_sv <= n_sv; r_sr <= n_sr; r_sb <= n_sb;
        r_div.num <= n_div.num; r_div.den <= n_div.den; r_div.steps <= n_div.steps;
        r_omean <= n_omean; r_oerr <= n_oerr; r_obin <= n_obin;
        r_oempty <= n_oempty; r_osat <= n_osat;
    end

    assign o_div_req    = r_div;
    assign o_valid      = r_ovalid;
    assign o_mean       = r_omean;
    assign o_mean_error = r_oerr;
    assign o_out_bin    = r_obin;
    assign o_empty_res  = r_oempty;
    assign o_saturated  = r_osat;

    // no weighted content without weight
    a_csum_needs_weight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_wsum == '0) |-> (r_csum == '0))
        else $error("weighted sum nonzero with zero weight sum");

    // an empty group reports zero mean and zero error
    a_empty_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ovalid && r_oempty) |-> (r_omean == '0 && r_oerr == '0))
        else $error("empty group with nonzero result");

    // divider start is only raised on entry to a state that waits for it
    a_div_start_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_div.start |-> (r_state == ST_RECW || r_state == ST_MEAN || r_state == ST_RECE))
        else $error("divider started outside a waiting state");

    // a new result only enters a free output slot
    a_out_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_OUT && r_ovalid && i_stall) |=> (r_state == ST_OUT))
        else $error("result left while output slot busy");

endmodule

// ----- hdl/inverse_variance_rebin_core.sv -----
// inverse_variance_rebin_core: top level, apb register, front queue, back sequencer
// and shared divider. depends on ivr_pkg, ivr_front, ivr_div, ivr_back
//
// Merges consecutive histogram bins (content and error, Q16.16) in groups of
// group_size into inverse-variance weighted means. A bin with zero error is
// skipped but still counts toward its group; first_bin restarts the grouping
// and the output index, dropping any partial group. A front queue of two entries
// takes input transactions, a back sequencer works one bin at a time. There a bin
// with an error of one raw unit gets a saturated weight, and any other bin with a
// nonzero error first waits for the 65-step reciprocal of its square on the shared
// one-bit-per-cycle divider. Closing a group runs the 80-step mean divide, the 65-step
// reciprocal of the weight sum and the square root, then loads the output register
// once it is not stalled; an empty group goes straight to that load. A finished result
// sits in the output register while the next bin is already accepted. group_size is
// written over apb at byte address 0 (values 0 act as 1, values above MAX_GROUP as
// MAX_GROUP); the user must write it only while idle, the block does not enforce it.
module inverse_variance_rebin_core #(
    parameter int MAX_GROUP    = ivr_pkg::MAX_GROUP_DEF,
    parameter int MAX_OUT_BINS = ivr_pkg::MAX_OUT_BINS_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    // apb configuration
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [ivr_pkg::ADDR_W-1:0] paddr,
    input  logic [31:0]                pwdata,
    output logic [31:0]                prdata,
    output logic                       pready,
    // bin input
    input  logic                       i_valid,
    output logic                       o_stall,
    input  logic [ivr_pkg::CW-1:0]     i_content,
    input  logic [ivr_pkg::CW-1:0]     i_bin_error,
    input  logic                       i_first_bin,
    // merged bin output
    output logic                       o_valid,
    input  logic                       i_stall,
    output logic [ivr_pkg::CW-1:0]     o_mean,
    output logic [ivr_pkg::CW-1:0]     o_mean_error,
    output logic [ivr_pkg::OB_W-1:0]   o_out_bin,
    output logic                       o_empty_res,
    output logic                       o_saturated
);

    logic [ivr_pkg::GS_W-1:0] r_group_size;
    logic                     cfg_wr;
    logic                     q_valid, q_pop;
    ivr_pkg::t_item           q_item;
    ivr_pkg::t_div_req        div_req;
    ivr_pkg::t_div_rsp        div_rsp;

    // register write at the access phase of a write transaction
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready
                    && (paddr[2] == ivr_pkg::REG_GROUP_SIZE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_group_size <= ivr_pkg::GS_W'(1);
        end else if (cfg_wr) begin
            r_group_size <= pwdata[ivr_pkg::GS_W-1:0];
        end
    end

    always_comb begin
        if (paddr[2] == ivr_pkg::REG_GROUP_SIZE) begin
            prdata = 32'(r_group_size);
        end else begin
            prdata = '0;
        end
    end

    // intake and classification
    ivr_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_content   (i_content),
        .i_bin_error (i_bin_error),
        .i_first_bin (i_first_bin),
        .i_pop       (q_pop),
        .o_q_valid   (q_valid),
        .o_q_item    (q_item)
    );

    // weights, accumulation, group close-out
    ivr_back #(
        .MAX_GROUP    (MAX_GROUP),
        .MAX_OUT_BINS (MAX_OUT_BINS)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_group_size (r_group_size),
        .i_q_valid    (q_valid),
        .i_q_item     (q_item),
        .o_pop        (q_pop),
        .o_div_req    (div_req),
        .i_div_rsp    (div_rsp),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_mean       (o_mean),
        .o_mean_error (o_mean_error),
        .o_out_bin    (o_out_bin),
        .o_empty_res  (o_empty_res),
        .o_saturated  (o_saturated)
    );

    // shared iterative divider
    ivr_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

endmodule
